/* rtl/ffha_pkg.sv */
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int unsigned HEAP_BYTES   = 512 * 1024;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned MAX_SEGS_DEF = 256;

  localparam int unsigned SIZE_W = $clog2(HEAP_BYTES + 1);
  localparam int unsigned OFF_W  = $clog2(HEAP_BYTES);
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned REQ_W  = 20;
  localparam int unsigned STAT_W = 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_OOM      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic              used;
    logic [OFF_W-1:0]  start;
    logic [SIZE_W-1:0] size;
  } seg_t;

  typedef struct packed {
    logic init;
    logic load;
    logic scan;
    logic next;
    logic plan;
    logic shift;
    logic wr0;
    logic wr1;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic trivial;
    logic hit;
    logic scan_end;
    logic shift_end;
    logic two_wr;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/ffha_ctrl.sv */
`timescale 1ns / 1ps

module ffha_ctrl import ffha_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_NEXT  = 4'd3;
  localparam logic [3:0] S_PLAN  = 4'd4;
  localparam logic [3:0] S_SHIFT = 4'd5;
  localparam logic [3:0] S_WR0   = 4'd6;
  localparam logic [3:0] S_WR1   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.trivial) begin
          state_d = S_DONE;
        end else if (sts_i.hit) begin
          state_d = S_NEXT;
        end else if (sts_i.scan_end) begin
          state_d = S_DONE;
        end
      end
      S_NEXT: begin
        cmd_o.next = 1'b1;
        state_d    = S_PLAN;
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_end) begin
          state_d = S_WR0;
        end
      end
      S_WR0: begin
        cmd_o.wr0 = 1'b1;
        state_d   = sts_i.two_wr ? S_WR1 : S_DONE;
      end
      S_WR1: begin
        cmd_o.wr1 = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/ffha_dp.sv */
`timescale 1ns / 1ps

module ffha_dp import ffha_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic              cfg_valid_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  input  logic              kind_i,
  input  logic [REQ_W-1:0]  request_bytes_i,
  input  logic [ADDR_W-1:0] pointer_address_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [ADDR_W-1:0] block_address_o,
  output logic [REQ_W-1:0]  granted_bytes_o,
  output logic [REQ_W-1:0]  used_bytes_o,
  output logic [REQ_W-1:0]  free_bytes_o
);

  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [SIZE_W-1:0] HDR_S = SIZE_W'(HEADER_BYTES);

  seg_t mem [MAX_SEGMENTS];
  seg_t rdata_q, cur_q, prv_q, nxt_q;

  logic [CNT_W-1:0]  count_q, addr_q, ridx_q, hidx_q, src_q, wdst_q;
  logic [CNT_W-1:0]  raddr;
  logic              pend_q, wv_q, found_q, nxt_ok_q, kind_q, triv_q;
  logic              sh_up_q, sh_act_q;
  logic [1:0]        sh_d_q;
  logic [SIZE_W:0]   rsize_q;
  logic [ADDR_W-1:0] base_q, bal_q, ptr_q;
  logic [SIZE_W-1:0] used_q, free_q, used_d, free_d;
  logic              ovalid_q;
  logic [STAT_W-1:0] ostat_q;
  logic [ADDR_W-1:0] oaddr_q;
  logic [SIZE_W-1:0] ogrant_q, oused_q, ofree_q;

  logic [ADDR_W-1:0] paddr_rd, paddr_cur;
  logic              match, in_tab, mn, mp, split, in_rng;
  logic [SIZE_W-1:0] grant, nsum, rel_size, hdr_add;
  logic [CNT_W-1:0]  w0_idx;
  seg_t              w0_data, w1_data;
  logic [STAT_W-1:0] res_stat;
  logic [ADDR_W:0]   base_sum;

  assign paddr_rd  = bal_q + ADDR_W'(rdata_q.start) + ADDR_W'(HEADER_BYTES);
  assign paddr_cur = bal_q + ADDR_W'(cur_q.start) + ADDR_W'(HEADER_BYTES);
  assign in_tab    = ridx_q < count_q;

  always_comb begin
    if (kind_q == KIND_FREE) begin
      match = rdata_q.used && (paddr_rd == ptr_q);
    end else begin
      match = !rdata_q.used && ({1'b0, rdata_q.size} >= rsize_q);
    end
  end

  assign mn    = nxt_ok_q && !nxt_q.used;
  assign mp    = (hidx_q != '0) && !prv_q.used;
  assign split = (kind_q == KIND_ALLOC)
              && ({1'b0, cur_q.size} >= rsize_q + (SIZE_W+1)'(HEADER_BYTES + ALIGN_BYTES))
              && (count_q < CNT_W'(MAX_SEGMENTS));
  assign grant    = split ? rsize_q[SIZE_W-1:0] : cur_q.size;
  assign nsum     = mn ? (HDR_S + nxt_q.size) : '0;
  assign rel_size = cur_q.size + nsum;
  assign hdr_add  = (mn && mp) ? SIZE_W'(2 * HEADER_BYTES) : ((mn || mp) ? HDR_S : '0);

  always_comb begin
    if (kind_q == KIND_ALLOC) begin
      w0_idx  = hidx_q;
      w0_data = '{used: 1'b1, start: cur_q.start, size: grant};
    end else if (mp) begin
      w0_idx  = hidx_q - CNT_W'(1);
      w0_data = '{used: 1'b0, start: prv_q.start, size: prv_q.size + HDR_S + rel_size};
    end else begin
      w0_idx  = hidx_q;
      w0_data = '{used: 1'b0, start: cur_q.start, size: rel_size};
    end
  end

  assign w1_data = '{used: 1'b0,
                     start: cur_q.start + OFF_W'(HEADER_BYTES) + rsize_q[OFF_W-1:0],
                     size: cur_q.size - rsize_q[SIZE_W-1:0] - HDR_S};

  assign in_rng = sh_act_q && (sh_up_q ? (src_q > hidx_q) : (src_q < count_q));
  assign raddr  = cmd_i.shift ? src_q : addr_q;

  assign sts_o.trivial   = triv_q;
  assign sts_o.hit       = pend_q && in_tab && match;
  assign sts_o.scan_end  = pend_q && !in_tab;
  assign sts_o.shift_end = !in_rng && !wv_q;
  assign sts_o.two_wr    = split;
  assign sts_o.out_free  = !ovalid_q || !out_stall_i;

  always_comb begin
    used_d = used_q;
    free_d = free_q;
    if (triv_q) begin
      res_stat = ST_NULL;
    end else if (!found_q) begin
      res_stat = (kind_q == KIND_FREE) ? ST_NOTFOUND : ST_OOM;
    end else begin
      res_stat = ST_OK;
      if (kind_q == KIND_ALLOC) begin
        used_d = used_q + grant;
        free_d = free_q - grant - (split ? HDR_S : '0);
      end else begin
        used_d = used_q - cur_q.size;
        free_d = free_q + cur_q.size + hdr_add;
      end
    end
  end

  assign base_sum = {1'b0, base_q} + (ADDR_W+1)'(ALIGN_BYTES - 1);

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr[IDX_W-1:0]];
    if (cmd_i.init) begin
      mem[0] <= '{used: 1'b0, start: '0, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)};
    end else if (cmd_i.shift && wv_q) begin
      mem[wdst_q[IDX_W-1:0]] <= rdata_q;
    end else if (cmd_i.wr0) begin
      mem[w0_idx[IDX_W-1:0]] <= w0_data;
    end else if (cmd_i.wr1) begin
      mem[IDX_W'(hidx_q + CNT_W'(1))] <= w1_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      ptr_q   <= pointer_address_i;
      rsize_q <= (SIZE_W+1)'(((SIZE_W+1)'(request_bytes_i) + (SIZE_W+1)'(ALIGN_BYTES - 1))
                 / ALIGN_BYTES * ALIGN_BYTES);
      triv_q  <= (kind_i == KIND_FREE) ? (pointer_address_i == '0)
                                       : (request_bytes_i == '0);
      bal_q   <= ADDR_W'(base_sum / ALIGN_BYTES * ALIGN_BYTES);
    end
    if (cmd_i.scan) begin
      ridx_q <= addr_q;
      if (pend_q && !sts_o.hit) begin
        prv_q <= rdata_q;
      end
      if (sts_o.hit) begin
        cur_q  <= rdata_q;
        hidx_q <= ridx_q;
      end
    end
    if (cmd_i.next) begin
      nxt_q    <= rdata_q;
      nxt_ok_q <= (hidx_q + CNT_W'(1)) < count_q;
    end
    if (cmd_i.plan) begin
      sh_up_q  <= (kind_q == KIND_ALLOC);
      sh_act_q <= (kind_q == KIND_ALLOC) ? split : (mn || mp);
      src_q    <= (kind_q == KIND_ALLOC) ? (count_q - CNT_W'(1))
                                         : (hidx_q + CNT_W'(1) + CNT_W'(mn));
      sh_d_q   <= 2'(mn) + 2'(mp);
    end else if (cmd_i.shift && in_rng) begin
      wdst_q <= sh_up_q ? (src_q + CNT_W'(1)) : (src_q - CNT_W'(sh_d_q));
      src_q  <= sh_up_q ? (src_q - CNT_W'(1)) : (src_q + CNT_W'(1));
    end
    if (cmd_i.commit) begin
      ostat_q  <= res_stat;
      oaddr_q  <= (res_stat == ST_OK && kind_q == KIND_ALLOC) ? paddr_cur : '0;
      ogrant_q <= (res_stat != ST_OK) ? '0 : ((kind_q == KIND_ALLOC) ? grant : cur_q.size);
      oused_q  <= used_d;
      ofree_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      count_q  <= CNT_W'(1);
      used_q   <= '0;
      free_q   <= SIZE_W'(HEAP_BYTES - HEADER_BYTES);
      addr_q   <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      wv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        addr_q  <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else if (cmd_i.scan) begin
        addr_q <= addr_q + CNT_W'(1);
        pend_q <= 1'b1;
        if (sts_o.hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.plan) begin
        wv_q <= 1'b0;
      end else if (cmd_i.shift) begin
        wv_q <= in_rng;
      end
      if (cmd_i.commit) begin
        used_q   <= used_d;
        free_q   <= free_d;
        ovalid_q <= 1'b1;
        if (res_stat == ST_OK) begin
          if (split) begin
            count_q <= count_q + CNT_W'(1);
          end else if (kind_q == KIND_FREE) begin
            count_q <= count_q - CNT_W'(sh_d_q);
          end
        end
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = ovalid_q;
  assign status_o        = ostat_q;
  assign block_address_o = oaddr_q;
  assign granted_bytes_o = REQ_W'(ogrant_q);
  assign used_bytes_o    = REQ_W'(oused_q);
  assign free_bytes_o    = REQ_W'(ofree_q);

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNT_W'(MAX_SEGMENTS)))
    else $error("Segment count left its range.");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && found_q && !triv_q) |=> (ostat_q == ST_OK))
    else $error("A found segment did not give an ok result.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !found_q) |=> (ogrant_q == '0 && oaddr_q == '0))
    else $error("A failed request reported a nonzero grant.");

endmodule

/* rtl/first_fit_heap_allocator_top.sv */
`timescale 1ns / 1ps
// The wait for a valid result grows with the number of segments scanned and the number of
// table entries moved by a split or merge; a miss scans the whole table.
// One item is in work at a time; the table memory port sets this.
// After reset the init state writes the first table entry before the first item is taken.
// The result register holds a finished item while the next item is accepted.

module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ADDR_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [REQ_W-1:0]  request_bytes_i,
  input  logic [ADDR_W-1:0] pointer_address_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [ADDR_W-1:0] block_address_o,
  output logic [REQ_W-1:0]  granted_bytes_o,
  output logic [REQ_W-1:0]  used_bytes_o,
  output logic [REQ_W-1:0]  free_bytes_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffha_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .kind_i            (kind_i),
    .request_bytes_i   (request_bytes_i),
    .pointer_address_i (pointer_address_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .block_address_o   (block_address_o),
    .granted_bytes_o   (granted_bytes_o),
    .used_bytes_o      (used_bytes_o),
    .free_bytes_o      (free_bytes_o)
  );

endmodule
